// File: rtl/core/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg: shared types and constants for the planar sprite to RGBA converter
// Payload structs, format modes, lane result type and the default palette.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int LANES     = 8;
    localparam int PAL_DEPTH = 16;
    localparam int PAL_AW    = 4;
    localparam int COLOR_W   = 24;
    localparam int PIXEL_W   = 32;
    localparam int MODE_W    = 2;

    localparam logic [7:0] LEVEL_HALF   = 8'h7f;
    localparam logic [7:0] LEVEL_FULL   = 8'hff;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INDEX_ONLY = 2'd0,
        MODE_MASK_INDEX = 2'd1,
        MODE_MASK_ONLY  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PX_OPAQUE,
        PX_CLEAR,
        PX_ZERO
    } px_kind_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  plane0_byte;
        logic [7:0]  plane1_byte;
        logic [7:0]  plane2_byte;
        logic [7:0]  plane3_byte;
        logic [7:0]  plane4_byte;
        logic [3:0]  entry_index;
        logic [23:0] entry_color;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel_0;
        logic [31:0] pixel_1;
        logic [31:0] pixel_2;
        logic [31:0] pixel_3;
        logic [31:0] pixel_4;
        logic [31:0] pixel_5;
        logic [31:0] pixel_6;
        logic [31:0] pixel_7;
    } result_t;

    typedef struct packed {
        px_kind_t             kind;
        logic [COLOR_W-1:0]   color;
    } lane_res_t;

    // index bits: blue bit 0, red bit 1, green bit 2, bit 3 selects level
    function automatic logic [COLOR_W-1:0] default_color(input logic [PAL_AW-1:0] idx);
        logic [7:0] lvl;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        lvl = idx[3] ? LEVEL_FULL : LEVEL_HALF;
        r   = idx[1] ? lvl : 8'h00;
        g   = idx[2] ? lvl : 8'h00;
        b   = idx[0] ? lvl : 8'h00;
        return {r, g, b};
    endfunction

endpackage

// File: rtl/core/psr_if.sv
// ----------------------------------------------------------------------------
// psr_if: valid/ready channels of the converter
// Item channel and pixel result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface psr_item_if;
    logic           valid;
    logic           ready;
    psr_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psr_result_if;
    logic             valid;
    logic             ready;
    psr_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/psr_lane.sv
// ----------------------------------------------------------------------------
// psr_lane: one pixel lane
// Own copy of the palette, index decode per mode and a registered lookup.
// ----------------------------------------------------------------------------
module psr_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [psr_pkg::PAL_AW-1:0]          wr_idx,
    input  logic [psr_pkg::COLOR_W-1:0]         wr_color,
    input  logic                                rd_en,
    input  logic [psr_pkg::MODE_W-1:0]          mode,
    input  logic [4:0]                          bits,
    output psr_pkg::lane_res_t                  res
);

    logic [psr_pkg::COLOR_W-1:0] palette_mem [psr_pkg::PAL_DEPTH];
    logic [psr_pkg::PAL_DEPTH-1:0] written_reg;
    logic [psr_pkg::PAL_DEPTH-1:0] written_next;

    logic [psr_pkg::PAL_AW-1:0]  rd_addr;
    psr_pkg::px_kind_t           kind;

    logic [psr_pkg::COLOR_W-1:0] rd_data_reg;
    logic [psr_pkg::PAL_AW-1:0]  rd_addr_reg;
    logic                        rd_hit_reg;
    psr_pkg::px_kind_t           kind_reg;

    always_comb
    begin
        rd_addr = '0;
        kind    = psr_pkg::PX_ZERO;
        case (mode)
            psr_pkg::MODE_INDEX_ONLY:
            begin
                rd_addr = bits[3:0];
                kind    = psr_pkg::PX_OPAQUE;
            end
            psr_pkg::MODE_MASK_INDEX:
            begin
                rd_addr = bits[0] ? bits[4:1] : '0;
                kind    = bits[0] ? psr_pkg::PX_OPAQUE : psr_pkg::PX_CLEAR;
            end
            psr_pkg::MODE_MASK_ONLY:
            begin
                kind    = bits[0] ? psr_pkg::PX_OPAQUE : psr_pkg::PX_ZERO;
            end
            default:
            begin
                kind    = psr_pkg::PX_ZERO;
            end
        endcase
    end

    always_comb
    begin
        written_next = written_reg;
        if (wr_en)
        begin
            written_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else
        begin
            written_reg <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_mem[wr_idx] <= wr_color;
        end
        if (rd_en)
        begin
            rd_data_reg <= palette_mem[rd_addr];
            rd_addr_reg <= rd_addr;
            rd_hit_reg  <= written_reg[rd_addr];
            kind_reg    <= kind;
        end
    end

    // entries never loaded read back as the power-up palette
    always_comb
    begin
        res.kind  = kind_reg;
        res.color = rd_hit_reg ? rd_data_reg : psr_pkg::default_color(rd_addr_reg);
    end

endmodule

// File: rtl/core/psr_merge.sv
// ----------------------------------------------------------------------------
// psr_merge: lane merge and output register
// Packs the eight lane lookups into RGBA words and holds the result.
// ----------------------------------------------------------------------------
module psr_merge (
    input  logic                                         clk,
    input  logic                                         load,
    input  psr_pkg::lane_res_t [psr_pkg::LANES-1:0]      lanes,
    output psr_pkg::result_t                             result
);

    logic [psr_pkg::LANES-1:0][psr_pkg::PIXEL_W-1:0] px;
    logic [psr_pkg::LANES-1:0][psr_pkg::PIXEL_W-1:0] px_reg;

    always_comb
    begin
        for (int j = 0; j < psr_pkg::LANES; j++)
        begin
            case (lanes[j].kind)
                psr_pkg::PX_OPAQUE: px[j] = {lanes[j].color, psr_pkg::ALPHA_OPAQUE};
                psr_pkg::PX_CLEAR:  px[j] = {lanes[j].color, psr_pkg::ALPHA_CLEAR};
                default:            px[j] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg <= px;
        end
    end

    assign result.pixel_0 = px_reg[0];
    assign result.pixel_1 = px_reg[1];
    assign result.pixel_2 = px_reg[2];
    assign result.pixel_3 = px_reg[3];
    assign result.pixel_4 = px_reg[4];
    assign result.pixel_5 = px_reg[5];
    assign result.pixel_6 = px_reg[6];
    assign result.pixel_7 = px_reg[7];

endmodule

// File: rtl/core/planar_sprite_to_rgba.sv
// ----------------------------------------------------------------------------
// planar_sprite_to_rgba: planar sprite bytes to RGBA pixels
// Eight lanes with private palette copies feed a merge/output register.
// ----------------------------------------------------------------------------
// One item per clock while the pixel output is not held by pixels.ready:
// a convert transaction is looked up into the lane read registers and then
// packed into eight RGBA pixels in the output register; a palette load
// yields nothing, and a load is seen by the very next convert. Throughput is
// set by the eight palette copies, one per lane, each with a single write and
// a single registered read port. The output register lets a new item in while
// a result waits. The palette powers up with the default sixteen colours
// without any clearing pass. A convert while format_mode is 3 is dropped.
// Write format_mode only while the block is idle.
module planar_sprite_to_rgba (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [psr_pkg::MODE_W-1:0]      cfg_wdata,
    psr_item_if.sink                        items,
    psr_result_if.source                    pixels
);

    logic [psr_pkg::MODE_W-1:0] format_mode_reg;
    logic                       lane_valid_reg;
    logic                       lane_valid_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic accept;
    logic conv_acc;
    logic load_wr;
    logic lane_adv;

    psr_pkg::lane_res_t [psr_pkg::LANES-1:0] lane_res;

    assign lane_adv     = !out_valid_reg || pixels.ready;
    assign items.ready  = !lane_valid_reg || lane_adv;
    assign accept       = items.valid && items.ready;
    assign load_wr      = accept && (items.data.cmd == psr_pkg::CMD_LOAD);
    assign conv_acc     = accept && (items.data.cmd == psr_pkg::CMD_CONVERT)
                          && (format_mode_reg <= psr_pkg::MODE_MASK_ONLY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= psr_pkg::MODE_INDEX_ONLY;
        end
        else if (cfg_we)
        begin
            format_mode_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        lane_valid_next = lane_valid_reg;
        out_valid_next  = out_valid_reg;
        if (items.ready)
        begin
            lane_valid_next = conv_acc;
        end
        if (lane_adv)
        begin
            out_valid_next = lane_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lane_valid_reg <= lane_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    genvar j;
    generate
        for (j = 0; j < psr_pkg::LANES; j++)
        begin : g_lane
            localparam int B = psr_pkg::LANES - 1 - j;
            psr_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr_en    (load_wr),
                .wr_idx   (items.data.entry_index),
                .wr_color (items.data.entry_color),
                .rd_en    (conv_acc),
                .mode     (format_mode_reg),
                .bits     ({items.data.plane4_byte[B], items.data.plane3_byte[B],
                            items.data.plane2_byte[B], items.data.plane1_byte[B],
                            items.data.plane0_byte[B]}),
                .res      (lane_res[j])
            );
        end
    endgenerate

    psr_merge u_merge (
        .clk    (clk),
        .load   (lane_adv && lane_valid_reg),
        .lanes  (lane_res),
        .result (pixels.data)
    );

    assign pixels.valid = out_valid_reg;

endmodule

// File: test/tb_planar_sprite_to_rgba.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_planar_sprite_to_rgba: self-checking bench for the planar to RGBA block
// Drives palette loads and convert transactions in every format mode, with
// random gaps on both handshakes, and checks each pixel row against a local
// predictor holding its own palette copy and mode.
// ----------------------------------------------------------------------------
module tb_planar_sprite_to_rgba;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         LATENCY_CYCLES = 4;
    localparam int         STALL_LIMIT    = 2000;
    localparam int         PHASE_ITEMS    = 80;
    localparam int         UNUSED_ITEMS   = 30;

    typedef logic [psr_pkg::LANES-1:0][psr_pkg::PIXEL_W-1:0] px_row_t;

    class pixel_scoreboard;
        logic [psr_pkg::COLOR_W-1:0] palette [psr_pkg::PAL_DEPTH];
        logic [1:0]                  mode;
        psr_pkg::result_t            expected_rows [$];
        int                          errors;

        function new();
            logic [7:0] lvl;
            for (int i = 0; i < psr_pkg::PAL_DEPTH; i++)
            begin
                lvl = i[3] ? 8'hff : 8'h7f;
                palette[i] = {i[1] ? lvl : 8'h00, i[2] ? lvl : 8'h00, i[0] ? lvl : 8'h00};
            end
            mode   = psr_pkg::MODE_INDEX_ONLY;
            errors = 0;
        endfunction

        function void set_mode(input logic [1:0] m);
            mode = m;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        function void note_item(input psr_pkg::item_t it);
            px_row_t    row;
            logic [3:0] idx;
            logic [4:0] b;
            int         sh;
            if (it.cmd == psr_pkg::CMD_LOAD)
            begin
                palette[it.entry_index] = it.entry_color;
                return;
            end
            if (mode == MODE_UNUSED)
                return;
            for (int j = 0; j < psr_pkg::LANES; j++)
            begin
                sh = 7 - j;
                b  = {it.plane4_byte[sh], it.plane3_byte[sh], it.plane2_byte[sh],
                      it.plane1_byte[sh], it.plane0_byte[sh]};
                case (mode)
                    psr_pkg::MODE_INDEX_ONLY:
                    begin
                        idx = b[3:0];
                        row[7-j] = {palette[idx], psr_pkg::ALPHA_OPAQUE};
                    end
                    psr_pkg::MODE_MASK_INDEX:
                    begin
                        idx = b[4:1];
                        row[7-j] = b[0] ? {palette[idx], psr_pkg::ALPHA_OPAQUE}
                                        : {palette[0], psr_pkg::ALPHA_CLEAR};
                    end
                    default:
                    begin
                        row[7-j] = b[0] ? {palette[0], psr_pkg::ALPHA_OPAQUE} : '0;
                    end
                endcase
            end
            expected_rows.push_back(row);
        endfunction

        function void check_result(input psr_pkg::result_t r);
            px_row_t exp_row;
            px_row_t act_row;
            if (expected_rows.size() == 0)
            begin
                $display("%0t: unexpected pixel transaction, actual %h", $time, r);
                errors++;
                return;
            end
            exp_row = expected_rows.pop_front();
            act_row = r;
            for (int j = 0; j < psr_pkg::LANES; j++)
            begin
                if (act_row[7-j] !== exp_row[7-j])
                begin
                    $display("%0t: pixel_%0d expected %h actual %h",
                             $time, j, exp_row[7-j], act_row[7-j]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [psr_pkg::MODE_W-1:0] cfg_wdata;

    psr_item_if   items_if ();
    psr_result_if pixels_if ();

    pixel_scoreboard sb;
    bit              no_gaps;
    int              stall_cycles;

    planar_sprite_to_rgba u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .items     (items_if),
        .pixels    (pixels_if)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // transactions on both channels, plus the no-progress watchdog
    always @(posedge clk)
    begin
        if (items_if.valid && items_if.ready)
            sb.note_item(items_if.data);
        if (pixels_if.valid && pixels_if.ready)
            sb.check_result(pixels_if.data);
        if ((items_if.valid && items_if.ready) || (pixels_if.valid && pixels_if.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] plane_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hff;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic psr_pkg::item_t make_item(input logic cmd, input logic [7:0] p0,
                                                 input logic [7:0] p1, input logic [7:0] p2,
                                                 input logic [7:0] p3, input logic [7:0] p4,
                                                 input logic [3:0] idx,
                                                 input logic [23:0] color);
        psr_pkg::item_t it;
        it.cmd         = cmd;
        it.plane0_byte = p0;
        it.plane1_byte = p1;
        it.plane2_byte = p2;
        it.plane3_byte = p3;
        it.plane4_byte = p4;
        it.entry_index = idx;
        it.entry_color = color;
        return it;
    endfunction

    function automatic psr_pkg::item_t random_item();
        int          r;
        logic [23:0] color;
        r = $urandom_range(0, 9);
        if (r == 0)
            color = 24'h000000;
        else if (r == 1)
            color = 24'hffffff;
        else
            color = 24'($urandom);
        return make_item(($urandom_range(0, 3) == 0) ? psr_pkg::CMD_LOAD : psr_pkg::CMD_CONVERT,
                         plane_byte(), plane_byte(), plane_byte(), plane_byte(),
                         plane_byte(), 4'($urandom_range(0, 15)), color);
    endfunction

    task automatic push_item(input psr_pkg::item_t it);
        int gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            items_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        items_if.valid <= 1'b1;
        items_if.data  <= it;
        @(posedge clk);
        while (!items_if.ready) @(posedge clk);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        items_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_results_drained();
        repeat (LATENCY_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_mode(m);
    endtask

    // result side back-pressure
    initial
    begin
        int stall;
        int run;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : idle_len();
            if (stall > 0)
            begin
                @(negedge clk);
                pixels_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            pixels_if.ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run - 1) @(negedge clk);
        end
    end

    initial
    begin
        logic [1:0] phase_modes [6];
        int         n;
        sb              = new();
        no_gaps         = 1'b0;
        stall_cycles    = 0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        items_if.valid  = 1'b0;
        items_if.data   = '0;
        pixels_if.ready = 1'b0;
        phase_modes = '{psr_pkg::MODE_MASK_ONLY, psr_pkg::MODE_MASK_INDEX,
                        psr_pkg::MODE_INDEX_ONLY, MODE_UNUSED,
                        psr_pkg::MODE_MASK_INDEX, psr_pkg::MODE_INDEX_ONLY};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // index only, default palette, then loads at the table ends and at entry 9
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'haa, 8'hcc, 8'hf0, 8'hff, 8'h00,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'haa, 8'hcc, 8'hf0, 8'h00, 8'hff,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            4'h0, 24'hffffff));
        push_item(make_item(psr_pkg::CMD_LOAD, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                            4'hf, 24'h000000));
        push_item(make_item(psr_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            4'h9, 24'ha5c35a));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'haa, 8'hcc, 8'hf0, 8'hff, 8'h00,
                            4'h0, 24'h0));

        write_mode(psr_pkg::MODE_MASK_INDEX);
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'ha5, 8'haa, 8'hcc, 8'hf0, 8'h0f,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff,
                            4'h0, 24'h0));

        write_mode(psr_pkg::MODE_MASK_ONLY);
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            4'h0, 24'h123456));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'h5a, 8'h00, 8'h00, 8'h00, 8'h00,
                            4'h0, 24'h0));

        // unused mode: converts dropped, loads still land
        write_mode(MODE_UNUSED);
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                            4'h0, 24'h0));
        push_item(make_item(psr_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            4'h0, 24'h00ff00));
        push_item(make_item(psr_pkg::CMD_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            4'h0, 24'h0));

        foreach (phase_modes[p])
        begin
            write_mode(phase_modes[p]);
            no_gaps = ($urandom_range(0, 3) == 0);
            n = (phase_modes[p] == MODE_UNUSED) ? UNUSED_ITEMS : PHASE_ITEMS;
            for (int i = 0; i < n; i++)
            begin
                if (i == n / 2)
                    wait_results_drained();
                push_item(random_item());
            end
        end

        no_gaps = 1'b0;
        wait_results_drained();
        repeat (2 * LATENCY_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
